/* hdl/dpbd_pkg.sv */
`default_nettype none

package dpbd_pkg;

    // page geometry
    localparam int PAGE_BYTES      = 16384;
    localparam int PAGE_AW         = 14;
    localparam int COLUMNS         = 10;
    localparam int VALUE_BYTES     = 100;
    localparam int TUPLES          = 15;
    localparam int PREFIX_BYTES    = 44;
    localparam int TUPLE_BYTES     = PREFIX_BYTES + 1004;
    localparam int COLS_END        = PREFIX_BYTES + COLUMNS * VALUE_BYTES;
    localparam int TAIL_BYTES      = 10;

    // compressed image layout
    localparam logic [31:0] MAGIC_WORD = 32'hC0DE_C0DE;
    localparam int HEADER_BYTES    = 8;
    localparam int MAGIC_BYTES     = 4;
    localparam int WIDTH_POS       = 6;
    localparam int IDS_POS         = HEADER_BYTES + TUPLES * PREFIX_BYTES;
    localparam int BANKS           = 4;
    localparam int BANK_DEPTH      = PAGE_BYTES / BANKS;
    localparam int BANK_AW         = PAGE_AW - 2;

    // item kinds
    localparam logic [1:0] KIND_LOAD_PAGE = 2'd0;
    localparam logic [1:0] KIND_LOAD_DICT = 2'd1;
    localparam logic [1:0] KIND_READ      = 2'd2;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_WIDTH = 2'd2;
    localparam logic [1:0] ST_BAD_ID    = 2'd3;

    // raw page regions
    localparam logic [1:0] REG_PAD    = 2'd0;
    localparam logic [1:0] REG_PREFIX = 2'd1;
    localparam logic [1:0] REG_COLUMN = 2'd2;
    localparam logic [1:0] REG_TAIL   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] off;
        logic [3:0]  col;
        logic [7:0]  entry;
        logic [7:0]  data;
        logic        last;
    } item_t;

    typedef struct packed {
        item_t       item;
        logic [3:0]  tup;
        logic [10:0] rem;
    } stage_b_t;

    typedef struct packed {
        logic [1:0] region;
        logic [1:0] status;
        logic [1:0] idw_sh;
        logic [3:0] dcol;
        logic [7:0] dent;
        logic [6:0] bidx;
        logic       dict_wr;
        logic [7:0] data;
        logic       last;
    } ctl_t;

    typedef struct packed {
        ctl_t        ctl;
        logic        is_wr;
        logic [13:0] ca;
    } stage_c_t;

    typedef struct packed {
        logic [1:0] region;
        logic [1:0] status;
        logic [7:0] cbyte;
        logic       dict_wr;
        logic [7:0] data;
        logic       last;
    } stage_e_t;

    typedef struct packed {
        logic [1:0] region;
        logic [1:0] status;
        logic [7:0] cbyte;
        logic       last;
    } stage_f_t;

    typedef struct packed {
        logic        access;
        logic        wr;
        logic [13:0] addr;
        logic [7:0]  wdata;
    } cpage_req_t;

endpackage

`default_nettype wire

/* hdl/dictionary_page_byte_decoder.sv */
`default_nettype none
// An accepted word passes through the stage registers a, b, c, d, e, f and then the output register.
// Throughput: one word per cycle sustained; seven-deep pipeline with bubble collapse,
// limited only by the output stall (page banks and dictionary are single-port, one access each).
// A column read does page id fetch (4 banks at once), then one dictionary read.
// Reset clears stage valid flags and the header shadow; both memories are not
// cleared and must be loaded before they are read.
module dictionary_page_byte_decoder
    import dpbd_pkg::*;
#(
    parameter int DICT_ENTRIES = 256
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         valid,
    output logic        stall,
    input  wire  [1:0]  kind,
    input  wire  [13:0] address,
    input  wire  [3:0]  column,
    input  wire  [7:0]  entry,
    input  wire  [7:0]  data,
    input  wire         range_end,
    output logic        res_valid,
    input  wire         res_stall,
    output logic [7:0]  byte_out,
    output logic [1:0]  status,
    output logic        last
);

    localparam int COL_SPAN   = DICT_ENTRIES * VALUE_BYTES;
    localparam int DICT_DEPTH = COLUMNS * COL_SPAN;
    localparam int DA_W       = $clog2(DICT_DEPTH);

    // stage handshake
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_out;
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, res_valid_reg;

    item_t    a_reg, a_next;
    stage_b_t b_reg, b_next;
    stage_c_t c_reg, c_next;
    ctl_t     d_reg;
    stage_e_t e_reg, e_next;
    stage_f_t f_reg;
    logic [DA_W-1:0] e_daddr_reg, e_daddr_next;
    logic [7:0]      dict_rd_reg;

    logic [7:0] byte_reg, byte_next;
    logic [1:0] status_reg;
    logic       last_reg;

    // header shadow, kept in step with page loads
    logic [31:0] magic_reg;
    logic [7:0]  width_reg;

    assign en_out = !res_valid_reg || !res_stall;
    assign en_f   = !f_v_reg || en_out;
    assign en_e   = !e_v_reg || en_f;
    assign en_d   = !d_v_reg || en_e;
    assign en_c   = !c_v_reg || en_d;
    assign en_b   = !b_v_reg || en_c;
    assign en_a   = !a_v_reg || en_b;
    assign stall  = !en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            d_v_reg       <= 1'b0;
            e_v_reg       <= 1'b0;
            f_v_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)   a_v_reg       <= valid;
            if (en_b)   b_v_reg       <= a_v_reg;
            if (en_c)   c_v_reg       <= b_v_reg;
            if (en_d)   d_v_reg       <= c_v_reg;
            if (en_e)   e_v_reg       <= d_v_reg;
            if (en_f)   f_v_reg       <= e_v_reg;
            if (en_out) res_valid_reg <= f_v_reg;
        end
    end

    // stage a: capture the word
    always_comb
    begin
        a_next.kind  = kind;
        a_next.off   = address;
        a_next.col   = column;
        a_next.entry = entry;
        a_next.data  = data;
        a_next.last  = range_end;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
            a_reg <= a_next;
    end

    // stage b: split offset into tuple and offset within tuple
    always_comb
    begin
        b_next.item = a_reg;
        b_next.tup  = 4'd0;
        for (int k = 1; k <= TUPLES; k++)
        begin
            if (a_reg.off >= 14'(k * TUPLE_BYTES))
                b_next.tup = 4'(k);
        end
        b_next.rem = 11'(a_reg.off - 14'(int'(b_next.tup) * TUPLE_BYTES));
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            b_reg <= b_next;
    end

    // snoop header bytes as page loads leave stage a
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= 32'd0;
            width_reg <= 8'd0;
        end
        else if (en_b && a_v_reg && (a_reg.kind == KIND_LOAD_PAGE))
        begin
            if (a_reg.off < 14'(MAGIC_BYTES))
                magic_reg[8*a_reg.off[1:0] +: 8] <= a_reg.data;
            if (a_reg.off == 14'(WIDTH_POS))
                width_reg <= a_reg.data;
        end
    end

    // stage c: region, checks and compressed byte address
    logic [3:0]  ccol;
    logic [6:0]  val_idx;
    logic [1:0]  idw_sh;
    logic        width_ok;
    logic [13:0] ids_addr, tail_addr, prefix_addr;
    logic [1:0]  read_region;

    always_comb
    begin
        ccol = 4'd0;
        for (int k = 1; k < COLUMNS; k++)
        begin
            if (b_reg.rem >= 11'(PREFIX_BYTES + k * VALUE_BYTES))
                ccol = 4'(k);
        end
        val_idx = 7'(b_reg.rem - 11'(PREFIX_BYTES) - 11'(int'(ccol) * VALUE_BYTES));

        width_ok = (width_reg == 8'd1) || (width_reg == 8'd2) || (width_reg == 8'd4);
        case (width_reg)
            8'd2:    idw_sh = 2'd1;
            8'd4:    idw_sh = 2'd2;
            default: idw_sh = 2'd0;
        endcase

        ids_addr    = 14'(IDS_POS)
                    + (14'(int'(b_reg.tup) * COLUMNS + int'(ccol)) << idw_sh);
        tail_addr   = 14'(IDS_POS) + (14'(TUPLES * COLUMNS) << idw_sh)
                    + 14'(b_reg.rem);
        prefix_addr = 14'(HEADER_BYTES) + 14'(int'(b_reg.tup) * PREFIX_BYTES)
                    + 14'(b_reg.rem);

        if (b_reg.tup == 4'(TUPLES))
            read_region = (b_reg.rem < 11'(TAIL_BYTES)) ? REG_TAIL : REG_PAD;
        else if (b_reg.rem < 11'(PREFIX_BYTES))
            read_region = REG_PREFIX;
        else if (b_reg.rem >= 11'(COLS_END))
            read_region = REG_PAD;
        else
            read_region = REG_COLUMN;

        c_next.ctl.region  = REG_PAD;
        c_next.ctl.status  = ST_OK;
        c_next.ctl.idw_sh  = idw_sh;
        c_next.ctl.dcol    = ccol;
        c_next.ctl.dent    = 8'd0;
        c_next.ctl.bidx    = val_idx;
        c_next.ctl.dict_wr = 1'b0;
        c_next.ctl.data    = b_reg.item.data;
        c_next.ctl.last    = b_reg.item.last;
        c_next.is_wr       = 1'b0;
        c_next.ca          = b_reg.item.off;

        case (b_reg.item.kind)
            KIND_LOAD_PAGE:
            begin
                c_next.is_wr = 1'b1;
            end
            KIND_LOAD_DICT:
            begin
                c_next.ctl.dcol    = b_reg.item.col;
                c_next.ctl.dent    = b_reg.item.entry;
                c_next.ctl.bidx    = b_reg.item.off[6:0];
                c_next.ctl.dict_wr = (b_reg.item.col < 4'(COLUMNS))
                                  && (b_reg.item.off < 14'(VALUE_BYTES))
                                  && ({24'd0, b_reg.item.entry} < 32'(DICT_ENTRIES));
            end
            KIND_READ:
            begin
                if (magic_reg != MAGIC_WORD)
                    c_next.ctl.status = ST_BAD_MAGIC;
                else if (!width_ok)
                    c_next.ctl.status = ST_BAD_WIDTH;
                c_next.ctl.region = read_region;
                case (read_region)
                    REG_PREFIX: c_next.ca = prefix_addr;
                    REG_COLUMN: c_next.ca = ids_addr;
                    REG_TAIL:   c_next.ca = tail_addr;
                    default:    c_next.ca = prefix_addr;
                endcase
            end
            default:
            begin
                c_next.is_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
            c_reg <= c_next;
    end

    // stage d: compressed page access (write, or read four bytes)
    cpage_req_t      cp_req;
    logic [3:0][7:0] cp_bytes;

    always_comb
    begin
        cp_req.access = en_d;
        cp_req.wr     = en_d && c_v_reg && c_reg.is_wr;
        cp_req.addr   = c_reg.ca;
        cp_req.wdata  = c_reg.ctl.data;
    end

    dpbd_cpage u_cpage
    (
        .clk      (clk),
        .req      (cp_req),
        .rd_bytes (cp_bytes)
    );

    always_ff @(posedge clk)
    begin
        if (en_d)
            d_reg <= c_reg.ctl;
    end

    // stage e: assemble id, range check, dictionary address
    logic [31:0] dict_id;
    logic [15:0] ent16;
    logic        bad_id;

    always_comb
    begin
        case (d_reg.idw_sh)
            2'd1:    dict_id = {16'd0, cp_bytes[1], cp_bytes[0]};
            2'd2:    dict_id = {cp_bytes[3], cp_bytes[2], cp_bytes[1], cp_bytes[0]};
            default: dict_id = {24'd0, cp_bytes[0]};
        endcase

        bad_id = (d_reg.region == REG_COLUMN) && (d_reg.status == ST_OK)
              && (dict_id >= 32'(DICT_ENTRIES));
        ent16  = (d_reg.region == REG_COLUMN) ? dict_id[15:0] : {8'd0, d_reg.dent};

        e_daddr_next = DA_W'(d_reg.dcol) * DA_W'(COL_SPAN)
                     + DA_W'(ent16) * DA_W'(VALUE_BYTES)
                     + DA_W'(d_reg.bidx);

        e_next.region  = d_reg.region;
        e_next.status  = bad_id ? ST_BAD_ID : d_reg.status;
        e_next.cbyte   = cp_bytes[0];
        e_next.dict_wr = d_reg.dict_wr;
        e_next.data    = d_reg.data;
        e_next.last    = d_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            e_reg       <= e_next;
            e_daddr_reg <= e_daddr_next;
        end
    end

    // stage f: dictionary access
    logic [7:0] dict_mem [DICT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            if (e_v_reg && e_reg.dict_wr)
                dict_mem[e_daddr_reg] <= e_reg.data;
            dict_rd_reg <= dict_mem[e_daddr_reg];
            f_reg.region <= e_reg.region;
            f_reg.status <= e_reg.status;
            f_reg.cbyte  <= e_reg.cbyte;
            f_reg.last   <= e_reg.last;
        end
    end

    // output register
    always_comb
    begin
        if (f_reg.status != ST_OK)
            byte_next = 8'd0;
        else
        begin
            case (f_reg.region)
                REG_COLUMN: byte_next = dict_rd_reg;
                REG_PREFIX: byte_next = f_reg.cbyte;
                REG_TAIL:   byte_next = f_reg.cbyte;
                default:    byte_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            byte_reg   <= byte_next;
            status_reg <= f_reg.status;
            last_reg   <= f_reg.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign byte_out  = byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // input stalls only with every stage full and the output blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> (a_v_reg && b_v_reg && c_v_reg && d_v_reg && e_v_reg && f_v_reg
                   && res_valid_reg && res_stall))
        else $error("input stalled with room in the pipeline");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status != ST_OK)) |-> (byte_out == 8'd0))
        else $error("nonzero byte on an error result");

    a_bad_id_column: assert property (@(posedge clk) disable iff (!rst_n)
        (f_v_reg && (f_reg.status == ST_BAD_ID)) |-> (f_reg.region == REG_COLUMN))
        else $error("id range error outside a column read");

    a_magic_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        (en_b && a_v_reg && (a_reg.kind == KIND_LOAD_PAGE) && (a_reg.off == 14'd0))
        |=> (magic_reg[7:0] == $past(a_reg.data)))
        else $error("header shadow missed a magic byte load");

endmodule

`default_nettype wire

/* hdl/dpbd_cpage.sv */
`default_nettype none

module dpbd_cpage
    import dpbd_pkg::*;
(
    input  wire        clk,
    input  cpage_req_t req,
    output logic [3:0][7:0] rd_bytes
);

    logic [1:0]      lane_reg;
    logic [3:0][7:0] bank_rd;

    // four byte-interleaved banks: any four consecutive bytes land in distinct banks
    genvar j;
    generate
        for (j = 0; j < BANKS; j++)
        begin : g_bank
            logic [7:0]         mem [BANK_DEPTH];
            logic [7:0]         rd_reg;
            logic [1:0]         k;
            logic [PAGE_AW-1:0] byte_addr;
            logic [BANK_AW-1:0] row;

            assign k         = 2'(j) - req.addr[1:0];
            assign byte_addr = req.addr + {{(PAGE_AW-2){1'b0}}, k};
            assign row       = byte_addr[PAGE_AW-1:2];

            always_ff @(posedge clk)
            begin
                if (req.access)
                begin
                    if (req.wr && (req.addr[1:0] == 2'(j)))
                        mem[row] <= req.wdata;
                    rd_reg <= mem[row];
                end
            end

            assign bank_rd[j] = rd_reg;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (req.access)
            lane_reg <= req.addr[1:0];
    end

    // rotate so that byte k is the one at address + k
    always_comb
    begin
        for (int n = 0; n < BANKS; n++)
            rd_bytes[n] = bank_rd[2'(lane_reg + 2'(n))];
    end

endmodule

`default_nettype wire
